### hdl/pwdm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwdm_pkg
// shared types, register codes and constants of the pulse width mapper
// ----------------------------------------------------------------------------
package pwdm_pkg;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration port
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [IDX_W-1:0] REG_FILTER_ALPHA     = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_IN_LOW_LIMIT     = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_IN_HIGH_LIMIT    = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_IN_CENTER        = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_CENTER_HALFWIDTH = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_OUT_LOW          = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_OUT_HIGH         = IDX_W'(6);

  // reset values
  localparam logic [16:0]        RST_FILTER_ALPHA     = 17'd65536;
  localparam logic [14:0]        RST_IN_LOW_LIMIT     = 15'd1000;
  localparam logic [14:0]        RST_IN_HIGH_LIMIT    = 15'd2000;
  localparam logic [14:0]        RST_IN_CENTER        = 15'd1500;
  localparam logic [13:0]        RST_CENTER_HALFWIDTH = 14'd50;
  localparam logic signed [15:0] RST_OUT_LOW          = 16'sd0;
  localparam logic signed [15:0] RST_OUT_HIGH         = 16'sd255;

  // alpha of one in q1.16
  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  // bucket numerator (offset times span) width, one divider step per bit
  localparam int unsigned NUM_W     = 31;
  localparam int unsigned DIV_STEPS = NUM_W;

  typedef struct packed {
    logic [16:0]        filter_alpha;
    logic [14:0]        in_low_limit;
    logic [14:0]        in_high_limit;
    logic [14:0]        in_center;
    logic [13:0]        center_halfwidth;
    logic signed [15:0] out_low;
    logic signed [15:0] out_high;
  } cfg_t;

  // classified word handed from front to back
  typedef struct packed {
    logic               is_div;   // needs the bucket division
    logic signed [15:0] value;    // final result, or bucket base
    logic [14:0]        offset;   // value minus range start, at least 1
    logic [16:0]        span;     // bucket count, 1 to 65536
    logic [15:0]        divisor;  // range length, 1 to 32768
  } entry_t;

endpackage
`default_nettype wire

### hdl/pwdm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwdm_queue
// small register queue of classified words between front and back
// ----------------------------------------------------------------------------
module pwdm_queue #(
  parameter int unsigned DEPTH = pwdm_pkg::QUEUE_DEPTH  // 2 or more
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pwdm_pkg::entry_t  wr_entry,
  output logic              full,
  input  logic              pop,
  output pwdm_pkg::entry_t  rd_entry,
  output logic              empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pwdm_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule
`default_nettype wire

### hdl/pwdm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwdm_front
// moving average update and region classification of each pulse width
// ----------------------------------------------------------------------------
module pwdm_front (
  input  logic              clk,
  input  logic              rst,
  input  pwdm_pkg::cfg_t    cfg,
  input  logic              push,
  output logic              full,
  input  logic [14:0]       pulse_width,
  output logic              q_push,
  output pwdm_pkg::entry_t  q_entry,
  input  logic              q_full
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_UPD, S_CLS} state_t;

  state_t              state;
  logic [14:0]         sample;
  logic [30:0]         avg;       // q15.16, never above 32767.0
  logic                loaded;
  logic signed [49:0]  prod;

  logic [16:0]         alpha_sat;
  logic signed [31:0]  delta;
  logic signed [33:0]  avg_sum;

  logic [14:0]         v;
  logic signed [17:0]  vs;
  logic signed [17:0]  lo;
  logic signed [17:0]  hi;
  logic signed [16:0]  out_sum;
  logic signed [16:0]  out_sum_adj;
  logic signed [15:0]  mid;
  logic                direct;
  logic signed [15:0]  direct_val;
  logic signed [17:0]  range_a;
  logic signed [17:0]  range_b;
  logic signed [17:0]  base_p;
  logic signed [17:0]  top_q;
  logic signed [17:0]  span;
  logic signed [17:0]  divisor;
  logic signed [17:0]  offset;

  // filter arithmetic
  assign alpha_sat = (cfg.filter_alpha > pwdm_pkg::ALPHA_ONE) ? pwdm_pkg::ALPHA_ONE
                                                              : cfg.filter_alpha;
  assign delta     = $signed({1'b0, sample, 16'd0}) - $signed({1'b0, avg});
  assign avg_sum   = $signed({3'b000, avg}) + $signed(prod[49:16]);

  // region limits and midpoint
  assign v           = avg[30:16];
  assign vs          = $signed({3'b000, v});
  assign lo          = $signed({3'b000, cfg.in_center}) - $signed({4'b0000, cfg.center_halfwidth});
  assign hi          = $signed({3'b000, cfg.in_center}) + $signed({4'b0000, cfg.center_halfwidth});
  assign out_sum     = $signed({cfg.out_low[15], cfg.out_low})
                     + $signed({cfg.out_high[15], cfg.out_high});
  // round toward zero: add one before the shift when negative
  assign out_sum_adj = out_sum + $signed({16'd0, out_sum[16]});
  assign mid         = out_sum_adj[16:1];

  always_comb begin
    direct     = 1'b1;
    direct_val = cfg.out_low;
    range_a    = '0;
    range_b    = '0;
    base_p     = '0;
    top_q      = '0;
    priority if (v <= cfg.in_low_limit) begin
      direct_val = cfg.out_low;
    end else if (v >= cfg.in_high_limit) begin
      direct_val = cfg.out_high;
    end else if (vs <= lo) begin
      direct  = 1'b0;
      range_a = $signed({3'b000, cfg.in_low_limit});
      range_b = lo;
      base_p  = 18'(cfg.out_low);
      top_q   = 18'(mid);
    end else if (vs <= hi) begin
      direct_val = mid;
    end else begin
      direct  = 1'b0;
      range_a = hi;
      range_b = $signed({3'b000, cfg.in_high_limit});
      base_p  = 18'(mid);
      top_q   = 18'(cfg.out_high);
    end
  end

  assign span    = top_q - base_p + 18'sd1;
  assign divisor = range_b - range_a + 18'sd1;
  assign offset  = vs - range_a;

  always_comb begin
    q_entry.is_div  = 1'b0;
    q_entry.value   = direct_val;
    q_entry.offset  = offset[14:0];
    q_entry.span    = span[16:0];
    q_entry.divisor = divisor[15:0];
    if (!direct) begin
      priority if (span <= 18'sd0) begin
        // empty or inverted span ends clamped at the top end
        q_entry.value = top_q[15:0];
      end else if (divisor <= 18'sd0) begin
        q_entry.value = base_p[15:0];
      end else begin
        q_entry.is_div = 1'b1;
        q_entry.value  = base_p[15:0];
      end
    end
  end

  assign full   = (state != S_IDLE);
  assign q_push = (state == S_CLS) && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      loaded <= 1'b0;
      avg    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (push) begin
            sample <= pulse_width;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          if (!loaded) begin
            avg    <= {sample, 16'd0};
            loaded <= 1'b1;
            state  <= S_CLS;
          end else begin
            prod  <= $signed({1'b0, alpha_sat}) * delta;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          avg   <= avg_sum[30:0];
          state <= S_CLS;
        end
        S_CLS: begin
          if (!q_full) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/pwdm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwdm_back
// bucket division, clamping and output register
// ----------------------------------------------------------------------------
module pwdm_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  pwdm_pkg::entry_t    q_entry,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output logic signed [15:0]  mapped_value
);

  localparam int unsigned STEP_W = $clog2(pwdm_pkg::DIV_STEPS);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_FIX, S_OUT} state_t;

  state_t                        state;
  pwdm_pkg::entry_t              cur;
  logic [pwdm_pkg::NUM_W-1:0]    num;      // numerator, becomes the quotient
  logic [15:0]                   rem;
  logic [STEP_W-1:0]             step;
  logic signed [15:0]            res;
  logic                          out_valid;
  logic                          out_load;

  logic [31:0]                   prod_w;
  logic [16:0]                   trial;
  logic                          fits;
  logic [16:0]                   trial_sub;
  logic [16:0]                   k;

  assign prod_w    = cur.offset * cur.span;
  assign trial     = {rem, num[pwdm_pkg::NUM_W-1]};
  assign fits      = (trial >= {1'b0, cur.divisor});
  assign trial_sub = trial - {1'b0, cur.divisor};
  assign k         = (num >= pwdm_pkg::NUM_W'(cur.span)) ? cur.span - 17'd1 : num[16:0];

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign empty    = !out_valid;
  // output register takes a new word when free or being read out
  assign out_load = (state == S_OUT) && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur   <= q_entry;
            res   <= q_entry.value;
            state <= q_entry.is_div ? S_MUL : S_OUT;
          end
        end
        S_MUL: begin
          num   <= prod_w[pwdm_pkg::NUM_W-1:0];
          rem   <= '0;
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= fits ? trial_sub[15:0] : trial[15:0];
          num  <= {num[pwdm_pkg::NUM_W-2:0], fits};
          step <= step + 1'b1;
          if (step == STEP_W'(pwdm_pkg::DIV_STEPS - 1)) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          res   <= cur.value + k[15:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            mapped_value <= res;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/pulse_width_deadband_mapper_unit.sv
`default_nettype none
// flow: the front multiplies, updates the average and classifies; the first sample
//   loads the average directly instead; bucketed words then pass the 31-step
//   restoring divider in the back
// handshake: the front takes no new word until the current one is queued, and the
//   back pulls no new word from the queue until its result is loaded for output
// reset: synchronous, clears the average, the queue and the output register,
//   and loads the configuration defaults
// ----------------------------------------------------------------------------
// pulse_width_deadband_mapper_unit
// smooths pulse widths with a moving average and maps them onto an output
// range with a center deadband
// ----------------------------------------------------------------------------
module pulse_width_deadband_mapper_unit #(
  parameter int unsigned QUEUE_DEPTH = pwdm_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  // input side
  input  logic                              push,
  output logic                              full,
  input  logic [14:0]                       pulse_width,
  // result side
  output logic                              empty,
  input  logic                              pop,
  output logic signed [15:0]                mapped_value,
  // configuration writes
  input  logic                              cfg_write,
  input  logic [pwdm_pkg::IDX_W-1:0]        cfg_index,
  input  logic [pwdm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pwdm_pkg::cfg_t    cfg;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  pwdm_pkg::entry_t  q_wr_entry;
  pwdm_pkg::entry_t  q_rd_entry;

  // configuration registers, each masked to its own width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_alpha     <= pwdm_pkg::RST_FILTER_ALPHA;
      cfg.in_low_limit     <= pwdm_pkg::RST_IN_LOW_LIMIT;
      cfg.in_high_limit    <= pwdm_pkg::RST_IN_HIGH_LIMIT;
      cfg.in_center        <= pwdm_pkg::RST_IN_CENTER;
      cfg.center_halfwidth <= pwdm_pkg::RST_CENTER_HALFWIDTH;
      cfg.out_low          <= pwdm_pkg::RST_OUT_LOW;
      cfg.out_high         <= pwdm_pkg::RST_OUT_HIGH;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pwdm_pkg::REG_FILTER_ALPHA:     cfg.filter_alpha     <= cfg_data;
        pwdm_pkg::REG_IN_LOW_LIMIT:     cfg.in_low_limit     <= cfg_data[14:0];
        pwdm_pkg::REG_IN_HIGH_LIMIT:    cfg.in_high_limit    <= cfg_data[14:0];
        pwdm_pkg::REG_IN_CENTER:        cfg.in_center        <= cfg_data[14:0];
        pwdm_pkg::REG_CENTER_HALFWIDTH: cfg.center_halfwidth <= cfg_data[13:0];
        pwdm_pkg::REG_OUT_LOW:          cfg.out_low          <= cfg_data[15:0];
        pwdm_pkg::REG_OUT_HIGH:         cfg.out_high         <= cfg_data[15:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // front: average update and classification into direct or bucketed words
  pwdm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .full        (full),
    .pulse_width (pulse_width),
    .q_push      (q_push),
    .q_entry     (q_wr_entry),
    .q_full      (q_full)
  );

  // decoupling queue so the front keeps filtering while the divider runs
  pwdm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_entry (q_rd_entry),
    .empty    (q_empty)
  );

  // back: bucket division and the result register seen on the ports
  pwdm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_entry      (q_rd_entry),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .mapped_value (mapped_value)
  );

endmodule
`default_nettype wire

### hdl/pwdm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwdm_checker
// port level checks of the pulse width mapper, bound to the top level
// ----------------------------------------------------------------------------
module pwdm_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               push,
  input wire logic               full,
  input wire logic               empty,
  input wire logic               pop,
  input wire logic signed [15:0] mapped_value
);

  logic [7:0] pending;  // words taken in and not yet handed out
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 1'b1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> full)
    else $error("second word taken while the first is still filtered");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(mapped_value)))
    else $error("waiting result changed or vanished");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (pending != 8'd0))
    else $error("result shown with no word outstanding");

endmodule

bind pulse_width_deadband_mapper_unit pwdm_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .push         (push),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .mapped_value (mapped_value)
);
`default_nettype wire

### bench/pwdm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwdm_tb_checker
// tracks register writes, predicts the mapped value of every accepted pulse
// width and compares each popped word against the oldest prediction
// ----------------------------------------------------------------------------
module pwdm_tb_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic                              full,
  input  logic [14:0]                       pulse_width,
  input  logic                              empty,
  input  logic                              pop,
  input  logic signed [15:0]                mapped_value,
  input  logic                              cfg_write,
  input  logic [pwdm_pkg::IDX_W-1:0]        cfg_index,
  input  logic [pwdm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                mismatch_count,
  output int                                open_words
);

  pwdm_pkg::cfg_t     regs;
  logic [31:0]        avg_q16;     // running average, q16.16
  logic               avg_valid;   // first sample seen
  logic signed [15:0] mapped_q[$];
  logic signed [15:0] want;

  function automatic longint bucket_pick(input longint v, a, b, p, q);
    longint count, spread, k;
    count  = q - p + 1;
    spread = b - a + 1;
    k      = 0;
    if (spread > 0) k = ((v - a) * count) / spread;
    if (k < 0) k = 0;
    if (k >= count) k = count - 1;
    return p + k;
  endfunction

  // updates the average and returns the mapped value
  function automatic logic signed [15:0] smooth_and_map(input logic [14:0] width);
    longint weight, target, avg, v, lo, hi, mid, r;
    longint low_lim, high_lim, olo, ohi;
    weight   = (regs.filter_alpha > pwdm_pkg::ALPHA_ONE) ? longint'(pwdm_pkg::ALPHA_ONE)
                                                         : longint'(regs.filter_alpha);
    target   = longint'(width) * 65536;
    avg      = longint'(avg_q16);
    if (!avg_valid) begin
      avg       = target;
      avg_valid = 1'b1;
    end else begin
      avg = avg + ((weight * (target - avg)) >>> 16);
    end
    avg_q16  = avg[31:0];
    v        = avg >>> 16;
    low_lim  = longint'(regs.in_low_limit);
    high_lim = longint'(regs.in_high_limit);
    olo      = longint'($signed(regs.out_low));
    ohi      = longint'($signed(regs.out_high));
    mid      = (olo + ohi) / 2;
    lo       = longint'(regs.in_center) - longint'(regs.center_halfwidth);
    hi       = longint'(regs.in_center) + longint'(regs.center_halfwidth);
    if (v <= low_lim) r = olo;
    else if (v >= high_lim) r = ohi;
    else if (v <= lo) r = bucket_pick(v, low_lim, lo, olo, mid);
    else if (v <= hi) r = mid;
    else r = bucket_pick(v, hi, high_lim, mid, ohi);
    return r[15:0];
  endfunction

  task automatic report_mismatch(input string what, input logic signed [15:0] got,
                                 input logic signed [15:0] exp_word);
    if (mismatch_count < 100)
      $display("%0t mapped_value %s: got %0d expected %0d", $time, what, got, exp_word);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs.filter_alpha     = pwdm_pkg::RST_FILTER_ALPHA;
      regs.in_low_limit     = pwdm_pkg::RST_IN_LOW_LIMIT;
      regs.in_high_limit    = pwdm_pkg::RST_IN_HIGH_LIMIT;
      regs.in_center        = pwdm_pkg::RST_IN_CENTER;
      regs.center_halfwidth = pwdm_pkg::RST_CENTER_HALFWIDTH;
      regs.out_low          = pwdm_pkg::RST_OUT_LOW;
      regs.out_high         = pwdm_pkg::RST_OUT_HIGH;
      avg_q16               = '0;
      avg_valid             = 1'b0;
      mapped_q.delete();
    end else begin
      // result side first, so a word can never match a same-edge push
      if (pop && !empty) begin
        if (mapped_q.size() == 0) begin
          report_mismatch("with nothing pending", mapped_value, 'x);
        end else begin
          want = mapped_q.pop_front();
          if (mapped_value !== want) report_mismatch("mismatch", mapped_value, want);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          pwdm_pkg::REG_FILTER_ALPHA:     regs.filter_alpha     = cfg_data;
          pwdm_pkg::REG_IN_LOW_LIMIT:     regs.in_low_limit     = cfg_data[14:0];
          pwdm_pkg::REG_IN_HIGH_LIMIT:    regs.in_high_limit    = cfg_data[14:0];
          pwdm_pkg::REG_IN_CENTER:        regs.in_center        = cfg_data[14:0];
          pwdm_pkg::REG_CENTER_HALFWIDTH: regs.center_halfwidth = cfg_data[13:0];
          pwdm_pkg::REG_OUT_LOW:          regs.out_low          = cfg_data[15:0];
          pwdm_pkg::REG_OUT_HIGH:         regs.out_high         = cfg_data[15:0];
          default: ;
        endcase
      end
      if (push && !full) mapped_q.push_back(smooth_and_map(pulse_width));
    end
    open_words <= mapped_q.size();
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives pulse widths and register settings into the mapper under random
// stalls on both sides; the checker predicts and compares every word
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 50;      // longer than the bucketed latency
  localparam int WIDTH_MAX     = 25000;   // pulse timeout
  // index past the last register, must be ignored by the block
  localparam logic [pwdm_pkg::IDX_W-1:0] REG_SPARE = pwdm_pkg::IDX_W'(7);

  logic                            clk         = 1'b0;
  logic                            rst         = 1'b1;
  logic                            push        = 1'b0;
  logic                            pop         = 1'b0;
  logic [14:0]                     pulse_width = '0;
  logic                            cfg_write   = 1'b0;
  logic [pwdm_pkg::IDX_W-1:0]      cfg_index   = pwdm_pkg::REG_FILTER_ALPHA;
  logic [pwdm_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
  logic                            full;
  logic                            empty;
  logic signed [15:0]              mapped_value;
  int                              mismatch_count;
  int                              open_words;

  // idle percentages of sender and receiver
  int send_idle = 0;
  int recv_idle = 0;
  // input window of the current settings, used to aim the random widths
  int win_lo = 0;
  int win_hi = WIDTH_MAX;
  int cycle_count = 0;

  pulse_width_deadband_mapper_unit dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .pulse_width  (pulse_width),
    .empty        (empty),
    .pop          (pop),
    .mapped_value (mapped_value),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  pwdm_tb_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .pulse_width    (pulse_width),
    .empty          (empty),
    .pop            (pop),
    .mapped_value   (mapped_value),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .open_words     (open_words)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver: one random pop decision per cycle
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** pulse_width_deadband_mapper_unit: FAILED **");
      $finish;
    end
  end

  // one register write; the caller drops the write enable after a batch
  task automatic write_reg(input logic [pwdm_pkg::IDX_W-1:0] idx,
                           input logic [pwdm_pkg::CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // full register set, plus a write to the unused index with junk data
  task automatic apply_config(input logic [16:0] alpha, input int low_lim, high_lim,
                              center, halfw, input logic signed [15:0] olo, ohi);
    write_reg(pwdm_pkg::REG_FILTER_ALPHA, alpha);
    write_reg(pwdm_pkg::REG_IN_LOW_LIMIT, pwdm_pkg::CFG_DATA_W'(low_lim));
    write_reg(pwdm_pkg::REG_IN_HIGH_LIMIT, pwdm_pkg::CFG_DATA_W'(high_lim));
    write_reg(pwdm_pkg::REG_IN_CENTER, pwdm_pkg::CFG_DATA_W'(center));
    write_reg(pwdm_pkg::REG_CENTER_HALFWIDTH, pwdm_pkg::CFG_DATA_W'(halfw));
    write_reg(pwdm_pkg::REG_OUT_LOW, pwdm_pkg::CFG_DATA_W'(olo));   // sign extends
    write_reg(pwdm_pkg::REG_OUT_HIGH, pwdm_pkg::CFG_DATA_W'(ohi));
    write_reg(REG_SPARE, pwdm_pkg::CFG_DATA_W'($urandom));
    cfg_write <= 1'b0;
    win_lo = (low_lim < high_lim) ? low_lim : high_lim;
    win_hi = (low_lim < high_lim) ? high_lim : low_lim;
  endtask

  // random gap, then hold push until the word is taken
  task automatic send_word(input logic [14:0] w);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    pulse_width <= w;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // wait until every predicted word has come out, then let the block settle;
  // the extra edge first lets the checker count take in the last push
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (open_words != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // kind 0: ordered limits around a center, kind 1: anything in range,
  // otherwise: every register but alpha at one of its extremes
  task automatic random_settings(input int kind);
    int                 low_lim, high_lim, center, halfw, pick;
    logic [16:0]        alpha;
    logic signed [15:0] olo, ohi;
    pick = $urandom_range(9);
    case (pick)
      0:       alpha = pwdm_pkg::ALPHA_ONE;
      1:       alpha = '0;
      2:       alpha = 17'($urandom_range(131071, 65537));   // saturates to one
      3, 4, 5: alpha = 17'($urandom_range(4096, 1));         // heavy smoothing
      default: alpha = 17'($urandom_range(65536, 4096));
    endcase
    olo = 16'($urandom);
    ohi = 16'($urandom);
    case (kind)
      0: begin
        low_lim  = $urandom_range(12000);
        high_lim = low_lim + $urandom_range(12000, 2);
        center   = $urandom_range(high_lim, low_lim);
        halfw    = $urandom_range((high_lim - low_lim) / 3);
        // narrow output ranges make the bucket edges land on many widths
        if ($urandom_range(1)) begin
          olo = 16'(int'($urandom_range(200)) - 100);
          ohi = 16'(int'(olo) + int'($urandom_range(400)) - 50);
        end
      end
      1: begin
        low_lim  = $urandom_range(WIDTH_MAX);
        high_lim = $urandom_range(WIDTH_MAX);
        center   = $urandom_range(WIDTH_MAX);
        halfw    = $urandom_range(12500);
      end
      default: begin
        low_lim  = $urandom_range(1) ? WIDTH_MAX : 0;
        high_lim = $urandom_range(1) ? WIDTH_MAX : 0;
        center   = $urandom_range(1) ? WIDTH_MAX : 0;
        halfw    = $urandom_range(1) ? 12500 : 0;
        olo      = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        ohi      = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      end
    endcase
    apply_config(alpha, low_lim, high_lim, center, halfw, olo, ohi);
  endtask

  // mostly widths around the active limits, some anywhere, some at the ends
  function automatic logic [14:0] next_width();
    int pick, lo, hi;
    pick = $urandom_range(9);
    lo   = (win_lo > 200) ? win_lo - 200 : 0;
    hi   = (win_hi + 200 < WIDTH_MAX) ? win_hi + 200 : WIDTH_MAX;
    if (pick < 6) return 15'($urandom_range(hi, lo));
    if (pick < 8) return 15'($urandom_range(WIDTH_MAX));
    return (pick == 8) ? 15'd0 : 15'(WIDTH_MAX);
  endfunction

  initial begin : stimulus
    // reset settings, no smoothing: every region edge of 1000 / 1450..1550 / 2000
    int boundary_widths[14] = '{0, 1000, 1001, 1200, 1449, 1450, 1451,
                                1500, 1550, 1551, 1800, 1999, 2000, 25000};
    // deadband reaching below zero, reversed output range
    int wild_widths[5] = '{1, 12500, 12501, 24999, 25000};
    // quarter-weight average walking across the buckets
    int step_widths[6] = '{2000, 1000, 1000, 1700, 1700, 1300};
    int phase, blk, count;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle = 37;
    recv_idle = 74;

    // first word loads the average directly
    foreach (boundary_widths[i]) send_word(15'(boundary_widths[i]));
    drain();

    // alpha above one saturates, deadband low end negative,
    // midpoint of -32768..32767 truncates to zero
    apply_config(17'h1ffff, 0, WIDTH_MAX, 0, 12500, 16'sh7fff, 16'sh8000);
    foreach (wild_widths[i]) send_word(15'(wild_widths[i]));
    drain();

    // odd output sum, midpoint of -3..4 truncates toward zero
    apply_config(17'd16384, 1000, 2000, 1500, 0, -16'sd3, 16'sd4);
    foreach (step_widths[i]) send_word(15'(step_widths[i]));
    drain();

    // random part: three stall patterns, a few register sets each
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 37;
          recv_idle = 74;
        end
        1: begin
          send_idle = 74;
          recv_idle = 37;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (blk = 0; blk < 4; blk++) begin
        random_settings(blk % 3);
        count = $urandom_range(100, 70);
        repeat (count) send_word(next_width());
        drain();
      end
    end

    if (mismatch_count == 0 && open_words == 0) begin
      $display("** pulse_width_deadband_mapper_unit: PASSED **");
    end else begin
      $display("** pulse_width_deadband_mapper_unit: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/pwdm_pkg.sv
hdl/pwdm_queue.sv
hdl/pwdm_front.sv
hdl/pwdm_back.sv
hdl/pulse_width_deadband_mapper_unit.sv
hdl/pwdm_checker.sv
bench/pwdm_checker.sv
bench/tb_top.sv
